[hdl/alpha_test_range_resolver_unit_defines.svh]
// ----------------------------------------------------------------------------
// Alpha test range resolver - assertion macros
// Assertion forms for the resolver's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ALPHA_TEST_RANGE_RESOLVER_UNIT_DEFINES_SVH
`define ALPHA_TEST_RANGE_RESOLVER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define ATRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define ATRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/atrr_pkg.sv]
// ----------------------------------------------------------------------------
// atrr_pkg
// Types, codes and constants of the alpha test range resolver.
// ----------------------------------------------------------------------------
package atrr_pkg;

  localparam logic [7:0]  ALPHA_FULL      = 8'hff;
  localparam logic [31:0] MASK_ALL        = 32'hffff_ffff;
  localparam logic [31:0] MASK_ALPHA_BYTE = 32'hff00_0000;
  localparam logic [7:0]  FIXED_ALPHA1_RST = 8'd128;

  typedef enum logic [1:0] {
    FMT_32  = 2'd0,
    FMT_24  = 2'd1,
    FMT_16  = 2'd2,
    FMT_PAL = 2'd3
  } fmt_class_t;

  typedef enum logic [1:0] {
    FN_MODULATE   = 2'd0,
    FN_DECAL      = 2'd1,
    FN_HIGHLIGHT  = 2'd2,
    FN_HIGHLIGHT2 = 2'd3
  } tex_func_t;

  typedef enum logic [2:0] {
    TM_NEVER    = 3'd0,
    TM_ALWAYS   = 3'd1,
    TM_LESS     = 3'd2,
    TM_LEQUAL   = 3'd3,
    TM_EQUAL    = 3'd4,
    TM_GEQUAL   = 3'd5,
    TM_GREATER  = 3'd6,
    TM_NOTEQUAL = 3'd7
  } test_mode_t;

  typedef enum logic [1:0] {
    FAIL_KEEP     = 2'd0,
    FAIL_FB_ONLY  = 2'd1,
    FAIL_ZB_ONLY  = 2'd2,
    FAIL_RGB_ONLY = 2'd3
  } fail_mode_t;

  typedef enum logic [2:0] {
    REG_ALPHA_EXPAND = 3'd0,
    REG_FIXED_ALPHA0 = 3'd1,
    REG_FIXED_ALPHA1 = 3'd2,
    REG_FMT_CLASS    = 3'd3,
    REG_TEX_FUNC     = 3'd4,
    REG_TEST_MODE    = 3'd5,
    REG_REF_ALPHA    = 3'd6,
    REG_FAIL_MODE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic       alpha_expand;
    logic [7:0] fixed_alpha0;
    logic [7:0] fixed_alpha1;
    fmt_class_t fmt_class;
    tex_func_t  tex_func;
    test_mode_t test_mode;
    logic [7:0] ref_alpha;
    fail_mode_t fail_mode;
  } cfg_t;

  // Texture range stage -> combine stage
  typedef struct packed {
    logic        tex_used;
    logic [7:0]  vtx_min;
    logic [7:0]  vtx_max;
    logic [7:0]  tex_min;
    logic [7:0]  tex_max;
    logic [31:0] frame_mask;
    logic [31:0] depth_mask;
  } s1_t;

  // Combine stage -> test stage
  typedef struct packed {
    logic [7:0]  amin;
    logic [7:0]  amax;
    logic [31:0] frame_mask;
    logic [31:0] depth_mask;
  } s2_t;

  // Test stage -> ports
  typedef struct packed {
    logic        decided;
    logic        all_pass;
    logic [31:0] frame_mask;
    logic [31:0] depth_mask;
    logic [7:0]  range_min;
    logic [7:0]  range_max;
  } res_t;

endpackage

[hdl/atrr_tex_range.sv]
// ----------------------------------------------------------------------------
// atrr_tex_range
// Stage 1: texture alpha range from the format class.
// ----------------------------------------------------------------------------
module atrr_tex_range (
  input  logic              clk,
  input  logic              rst_n,
  input  atrr_pkg::cfg_t    cfg,
  input  logic              in_vld,
  input  logic              tex_used,
  input  logic [7:0]        vtx_min,
  input  logic [7:0]        vtx_max,
  input  logic [7:0]        pal_min,
  input  logic [7:0]        pal_max,
  input  logic [31:0]       frame_mask,
  input  logic [31:0]       depth_mask,
  output logic              out_vld,
  output atrr_pkg::s1_t     out_data
);

  logic          vld_r;
  atrr_pkg::s1_t data_r;
  atrr_pkg::s1_t data_nxt;
  logic [7:0]    fa_lo;
  logic [7:0]    fa_hi;

  always_comb begin
    fa_lo = (cfg.fixed_alpha0 < cfg.fixed_alpha1) ? cfg.fixed_alpha0 : cfg.fixed_alpha1;
    fa_hi = (cfg.fixed_alpha0 > cfg.fixed_alpha1) ? cfg.fixed_alpha0 : cfg.fixed_alpha1;
    data_nxt            = '0;
    data_nxt.tex_used   = tex_used;
    data_nxt.vtx_min    = vtx_min;
    data_nxt.vtx_max    = vtx_max;
    data_nxt.frame_mask = frame_mask;
    data_nxt.depth_mask = depth_mask;
    case (cfg.fmt_class)
      atrr_pkg::FMT_32: begin
        data_nxt.tex_min = 8'd0;
        data_nxt.tex_max = atrr_pkg::ALPHA_FULL;
      end
      atrr_pkg::FMT_24: begin
        data_nxt.tex_min = cfg.alpha_expand ? 8'd0 : cfg.fixed_alpha0;
        data_nxt.tex_max = cfg.fixed_alpha0;
      end
      atrr_pkg::FMT_16: begin
        data_nxt.tex_min = cfg.alpha_expand ? 8'd0 : fa_lo;
        data_nxt.tex_max = fa_hi;
      end
      default: begin
        data_nxt.tex_min = pal_min;
        data_nxt.tex_max = pal_max;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

[hdl/atrr_combine.sv]
// ----------------------------------------------------------------------------
// atrr_combine
// Stage 2: texture function applied to each bound of the range when the texture is used.
// ----------------------------------------------------------------------------
module atrr_combine (
  input  logic              clk,
  input  logic              rst_n,
  input  atrr_pkg::cfg_t    cfg,
  input  logic              in_vld,
  input  atrr_pkg::s1_t     in_data,
  output logic              out_vld,
  output atrr_pkg::s2_t     out_data
);

  logic          vld_r;
  atrr_pkg::s2_t data_r;
  atrr_pkg::s2_t data_nxt;

  // One bound: 8x8 product or 9-bit sum, each saturated to a byte, or the texture bound
  function automatic logic [7:0] comb_bound(atrr_pkg::tex_func_t fn,
                                            logic [7:0] vtx, logic [7:0] tex);
    logic [15:0] prod;
    logic [8:0]  sum;
    logic [7:0]  res;
    prod = 16'(vtx) * 16'(tex);
    sum  = 9'(vtx) + 9'(tex);
    case (fn)
      atrr_pkg::FN_MODULATE:  res = prod[15] ? atrr_pkg::ALPHA_FULL : prod[14:7];
      atrr_pkg::FN_HIGHLIGHT: res = sum[8] ? atrr_pkg::ALPHA_FULL : sum[7:0];
      default:                res = tex;
    endcase
    return res;
  endfunction

  always_comb begin
    data_nxt.frame_mask = in_data.frame_mask;
    data_nxt.depth_mask = in_data.depth_mask;
    if (in_data.tex_used) begin
      data_nxt.amin = comb_bound(cfg.tex_func, in_data.vtx_min, in_data.tex_min);
      data_nxt.amax = comb_bound(cfg.tex_func, in_data.vtx_max, in_data.tex_max);
    end else begin
      data_nxt.amin = in_data.vtx_min;
      data_nxt.amax = in_data.vtx_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

[hdl/atrr_test.sv]
// ----------------------------------------------------------------------------
// atrr_test
// Stage 3: alpha test over the range, fail handling, result register.
// ----------------------------------------------------------------------------
module atrr_test (
  input  logic              clk,
  input  logic              rst_n,
  input  atrr_pkg::cfg_t    cfg,
  input  logic              in_vld,
  input  atrr_pkg::s2_t     in_data,
  output logic              out_vld,
  output atrr_pkg::res_t    out_data
);

  logic           vld_r;
  atrr_pkg::res_t data_r;
  atrr_pkg::res_t data_nxt;
  logic           decided;
  logic           pass;
  logic [7:0]     r;

  always_comb begin
    r       = cfg.ref_alpha;
    decided = 1'b1;
    pass    = 1'b1;
    case (cfg.test_mode)
      atrr_pkg::TM_NEVER:  pass = 1'b0;
      atrr_pkg::TM_ALWAYS: pass = 1'b1;
      atrr_pkg::TM_LESS: begin
        if (in_data.amax < r)       pass = 1'b1;
        else if (in_data.amin >= r) pass = 1'b0;
        else                        decided = 1'b0;
      end
      atrr_pkg::TM_LEQUAL: begin
        if (in_data.amax <= r)      pass = 1'b1;
        else if (in_data.amin > r)  pass = 1'b0;
        else                        decided = 1'b0;
      end
      atrr_pkg::TM_EQUAL: begin
        if (in_data.amin == r && in_data.amax == r)     pass = 1'b1;
        else if (in_data.amin > r || in_data.amax < r)  pass = 1'b0;
        else                                            decided = 1'b0;
      end
      atrr_pkg::TM_GEQUAL: begin
        if (in_data.amin >= r)      pass = 1'b1;
        else if (in_data.amax < r)  pass = 1'b0;
        else                        decided = 1'b0;
      end
      atrr_pkg::TM_GREATER: begin
        if (in_data.amin > r)       pass = 1'b1;
        else if (in_data.amax <= r) pass = 1'b0;
        else                        decided = 1'b0;
      end
      default: begin
        if (in_data.amin == r && in_data.amax == r)     pass = 1'b0;
        else if (in_data.amin > r || in_data.amax < r)  pass = 1'b1;
        else                                            decided = 1'b0;
      end
    endcase

    data_nxt.decided    = decided;
    data_nxt.all_pass   = decided && pass;
    data_nxt.range_min  = in_data.amin;
    data_nxt.range_max  = in_data.amax;
    data_nxt.frame_mask = in_data.frame_mask;
    data_nxt.depth_mask = in_data.depth_mask;
    if (decided && !pass) begin
      case (cfg.fail_mode)
        atrr_pkg::FAIL_KEEP: begin
          data_nxt.frame_mask = atrr_pkg::MASK_ALL;
          data_nxt.depth_mask = atrr_pkg::MASK_ALL;
        end
        atrr_pkg::FAIL_FB_ONLY: data_nxt.depth_mask = atrr_pkg::MASK_ALL;
        atrr_pkg::FAIL_ZB_ONLY: data_nxt.frame_mask = atrr_pkg::MASK_ALL;
        default: begin
          data_nxt.frame_mask = in_data.frame_mask | atrr_pkg::MASK_ALPHA_BYTE;
          data_nxt.depth_mask = atrr_pkg::MASK_ALL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

[hdl/alpha_test_range_resolver_unit.sv]
// ----------------------------------------------------------------------------
// alpha_test_range_resolver_unit
// Per-primitive alpha range and alpha test resolution, three-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  input     | start / busy           | in_color_alpha_*, in_tex_alpha_used,
//            |                        | in_palette_alpha_*, in_*_mask_in
//  result    | out_valid (strobe)     | out_decided, out_all_pass, out_*_mask,
//            |                        | out_range_min, out_range_max
//  config    | cfg_we                 | cfg_addr, cfg_data
//
// One word is taken every cycle while busy is low; its strobe follows through the
// texture range, combine and test/fail registers.
// busy is high while rst_n is low and until the first edge that sees it high; traffic
// never raises it, since every stage advances every cycle.
// The receiver cannot stall: out_valid lasts one cycle per word.
// Reset clears the valid bits and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`include "alpha_test_range_resolver_unit_defines.svh"

module alpha_test_range_resolver_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  // input words
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_color_alpha_min,
  input  logic [7:0]  in_color_alpha_max,
  input  logic        in_tex_alpha_used,
  input  logic [7:0]  in_palette_alpha_min,
  input  logic [7:0]  in_palette_alpha_max,
  input  logic [31:0] in_frame_mask_in,
  input  logic [31:0] in_depth_mask_in,
  // result words
  output logic        out_valid,
  output logic        out_decided,
  output logic        out_all_pass,
  output logic [31:0] out_frame_mask_out,
  output logic [31:0] out_depth_mask_out,
  output logic [7:0]  out_range_min,
  output logic [7:0]  out_range_max
);

  atrr_pkg::cfg_t cfg_r;
  logic           busy_r;
  logic           accept;

  logic           s1_vld;
  atrr_pkg::s1_t  s1_data;
  logic           s2_vld;
  atrr_pkg::s2_t  s2_data;
  logic           res_vld;
  atrr_pkg::res_t res_data;

  // Words offered while busy is high are dropped
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Configuration registers; only the low bits a register needs are kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_expand <= 1'b0;
      cfg_r.fixed_alpha0 <= 8'd0;
      cfg_r.fixed_alpha1 <= atrr_pkg::FIXED_ALPHA1_RST;
      cfg_r.fmt_class    <= atrr_pkg::FMT_32;
      cfg_r.tex_func     <= atrr_pkg::FN_MODULATE;
      cfg_r.test_mode    <= atrr_pkg::TM_ALWAYS;
      cfg_r.ref_alpha    <= 8'd0;
      cfg_r.fail_mode    <= atrr_pkg::FAIL_KEEP;
    end else if (cfg_we) begin
      case (atrr_pkg::cfg_idx_t'(cfg_addr))
        atrr_pkg::REG_ALPHA_EXPAND: cfg_r.alpha_expand <= cfg_data[0];
        atrr_pkg::REG_FIXED_ALPHA0: cfg_r.fixed_alpha0 <= cfg_data;
        atrr_pkg::REG_FIXED_ALPHA1: cfg_r.fixed_alpha1 <= cfg_data;
        atrr_pkg::REG_FMT_CLASS:
          cfg_r.fmt_class <= atrr_pkg::fmt_class_t'(cfg_data[1:0]);
        atrr_pkg::REG_TEX_FUNC:
          cfg_r.tex_func <= atrr_pkg::tex_func_t'(cfg_data[1:0]);
        atrr_pkg::REG_TEST_MODE:
          cfg_r.test_mode <= atrr_pkg::test_mode_t'(cfg_data[2:0]);
        atrr_pkg::REG_REF_ALPHA:    cfg_r.ref_alpha <= cfg_data;
        atrr_pkg::REG_FAIL_MODE:
          cfg_r.fail_mode <= atrr_pkg::fail_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Stage 1: texture alpha range
  atrr_tex_range u_tex_range (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_vld     (accept),
    .tex_used   (in_tex_alpha_used),
    .vtx_min    (in_color_alpha_min),
    .vtx_max    (in_color_alpha_max),
    .pal_min    (in_palette_alpha_min),
    .pal_max    (in_palette_alpha_max),
    .frame_mask (in_frame_mask_in),
    .depth_mask (in_depth_mask_in),
    .out_vld    (s1_vld),
    .out_data   (s1_data)
  );

  // Stage 2: vertex and texture ranges combined
  atrr_combine u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_vld   (s1_vld),
    .in_data  (s1_data),
    .out_vld  (s2_vld),
    .out_data (s2_data)
  );

  // Stage 3: alpha test resolution and fail masks
  atrr_test u_test (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_vld   (s2_vld),
    .in_data  (s2_data),
    .out_vld  (res_vld),
    .out_data (res_data)
  );

  assign out_valid          = res_vld;
  assign out_decided        = res_data.decided;
  assign out_all_pass       = res_data.all_pass;
  assign out_frame_mask_out = res_data.frame_mask;
  assign out_depth_mask_out = res_data.depth_mask;
  assign out_range_min      = res_data.range_min;
  assign out_range_max      = res_data.range_max;

  // An accepted word reaches the combine stage on the next edge
  `ATRR_ASSERT_NEXT(a_s1_follows_accept, accept, s1_vld,
                    "accepted word did not enter stage 2")

  // Every valid test-stage input produces a result strobe
  `ATRR_ASSERT_NEXT(a_res_follows_s2, s2_vld, out_valid,
                    "stage 3 word lost before the result port")

  // A pass claim is only made for a decided range
  `ATRR_ASSERT_NOW(a_pass_needs_decided, out_valid && out_all_pass, out_decided,
                   "all_pass reported for an undecided range")

  // A decided fail under keep mode leaves both masks at all ones
  `ATRR_ASSERT_NOW(a_keep_masks,
                   out_valid && out_decided && !out_all_pass &&
                   cfg_r.fail_mode == atrr_pkg::FAIL_KEEP,
                   out_frame_mask_out == atrr_pkg::MASK_ALL &&
                   out_depth_mask_out == atrr_pkg::MASK_ALL,
                   "keep fail mode did not force both masks")

endmodule
